// File: hw/rtl/vosp_pkg.sv
// vosp_pkg: shared types, constants and helpers for the voxel order sort block.
// No dependencies.
`default_nettype none
package vosp_pkg;
  localparam int unsigned MaxParticlesDef = 64;
  localparam int unsigned KeyW = 64;
  localparam int unsigned VoxW = 16;
  localparam logic [31:0] ScaleReset = 32'd65536;
  localparam logic [0:0] RegScale = 1'b0;

  typedef enum logic [1:0] {
    ST_LOAD = 2'd0,
    ST_MUL  = 2'd1,
    ST_INS  = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;   // latch input word, start multiply
    logic insert;    // place key into sorted chain
    logic emit_load; // load output register from the slot at the emit pointer
    logic emit_clr;  // set emptied, reset count
  } cmd_t;

  typedef struct packed {
    logic full;
    logic emit_done; // current emit slot is the last one
  } sts_t;

  // Saturated floor(raw * scale / 2^32) given the 64-bit magnitude product.
  function automatic logic [VoxW-1:0] sat_voxel(input logic neg, input logic [63:0] prod);
    logic [32:0] q;
    begin
      q = {1'b0, prod[63:32]};
      if (neg) begin
        if (prod[31:0] != 32'd0) q = q + 33'd1;
        if (q >= 33'd32768) sat_voxel = 16'h8000;
        else sat_voxel = 16'(~q[15:0] + 16'd1);
      end else begin
        if (q > 33'd32767) sat_voxel = 16'h7FFF;
        else sat_voxel = q[15:0];
      end
    end
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/vosp_ctrl.sv
// vosp_ctrl: controller state machine of the voxel order sort block.
// Depends on vosp_pkg.
`default_nettype none
module vosp_ctrl
  import vosp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic in_final,
  input  wire logic out_free,
  input  wire sts_t sts,
  output logic      in_ok,
  output cmd_t      cmd
);
  state_t state, state_next;
  logic fin, fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
    end
  end

  always_comb begin
    state_next = state;
    fin_next = fin;
    cmd = '0;
    in_ok = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ok = 1'b1;
        if (in_fire) begin
          cmd.capture = 1'b1;
          fin_next = in_final;
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_INS;
      ST_INS: begin
        cmd.insert = !sts.full;
        state_next = fin ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_done) begin
            cmd.emit_clr = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/vosp_dp.sv
// vosp_dp: datapath: multipliers, insertion chain, emit pointer, output register.
// Depends on vosp_pkg.
`default_nettype none
module vosp_dp
  import vosp_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = MaxParticlesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [31:0] scale,
  input  wire logic [31:0] px,
  input  wire logic [31:0] py,
  input  wire logic [31:0] pz,
  input  wire logic        out_take,
  output sts_t             sts,
  output logic             out_valid,
  output logic [5:0]       o_index,
  output logic [2:0]       o_part,
  output logic             o_start,
  output logic             o_last
);
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  logic [31:0] mag [3];
  logic        neg [3];
  logic [31:0] zraw;
  logic [63:0] prod [3];
  logic        pneg [3];

  // chain entries: key (vx,vy,z biased), owner, parity, vz
  logic [KeyW-1:0] key_q [MAX_PARTICLES];
  logic [5:0]      own_q [MAX_PARTICLES];
  logic [2:0]      par_q [MAX_PARTICLES];
  logic [VoxW-1:0] vz_q  [MAX_PARTICLES];
  logic [CW-1:0]   count;
  logic [CW-1:0]   rd;
  logic [KeyW-1:0] new_key;
  logic [VoxW-1:0] vx, vy, vz;
  logic [MAX_PARTICLES-1:0] gt;

  // stage 1: register magnitudes
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      neg[0] <= px[31]; mag[0] <= px[31] ? 32'(-px) : px;
      neg[1] <= py[31]; mag[1] <= py[31] ? 32'(-py) : py;
      neg[2] <= pz[31]; mag[2] <= pz[31] ? 32'(-pz) : pz;
      zraw <= pz;
    end
  end

  // stage 2: three 32x32 products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= 64'(mag[i]) * 64'(scale);
      pneg[i] <= neg[i];
    end
  end

  always_comb begin
    vx = sat_voxel(pneg[0], prod[0]);
    vy = sat_voxel(pneg[1], prod[1]);
    vz = sat_voxel(pneg[2], prod[2]);
    new_key = {vx ^ 16'h8000, vy ^ 16'h8000, zraw ^ 32'h8000_0000};
    for (int i = 0; i < MAX_PARTICLES; i++)
      gt[i] = (CW'(i) < count) && (key_q[i] > new_key);
  end

  assign sts = '{full: (count == CW'(MAX_PARTICLES)),
                 emit_done: (CW'(rd + CW'(1)) >= count)};

  // insertion chain: each slot holds, shifts up, or takes the new key
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < MAX_PARTICLES; i++) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          key_q[i] <= key_q[(i > 0) ? i - 1 : 0];
          own_q[i] <= own_q[(i > 0) ? i - 1 : 0];
          par_q[i] <= par_q[(i > 0) ? i - 1 : 0];
          vz_q[i]  <= vz_q[(i > 0) ? i - 1 : 0];
        end else if ((gt[i] || CW'(i) == count) && (i == 0 || !gt[(i > 0) ? i - 1 : 0])) begin
          key_q[i] <= new_key;
          own_q[i] <= 6'(count);
          par_q[i] <= {vz[0], vy[0], vx[0]};
          vz_q[i]  <= vz;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_clr) begin
        count <= '0;
        rd <= '0;
      end else begin
        if (cmd.insert) count <= count + CW'(1);
        if (cmd.emit_load) rd <= rd + CW'(1);
      end
      if (cmd.emit_load) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      o_index <= own_q[rd[IW-1:0]];
      o_part  <= par_q[rd[IW-1:0]];
      o_last  <= sts.emit_done;
      o_start <= (rd == '0) ||
                 (key_q[rd[IW-1:0]][63:32] != key_q[IW'(rd[IW-1:0] - IW'(1))][63:32]) ||
                 (vz_q[rd[IW-1:0]] != vz_q[IW'(rd[IW-1:0] - IW'(1))]);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/voxel_order_sort_partition.sv
// voxel_order_sort_partition: top level, APB register, stream ports, ctrl + datapath.
// Depends on vosp_pkg, vosp_ctrl, vosp_dp.
`default_nettype none
// Loads particle positions (Q16.16) one word at a time, converts them to
// saturated voxel coordinates using voxel_scale, and keeps them in a sorted
// insertion chain keyed by (voxel x, voxel y, raw z), stable on ties. A word
// with tuser (final_particle) set closes the set: the block then streams one
// word per loaded particle in key order and empties itself. Each input word
// passes the load state (capture), the multiply state and the key/insert
// state, fed by the registered magnitude and 32x32 multiply stages ahead of
// the chain, before the next word is taken; output-side stalls hold the
// emission. Words beyond MAX_PARTICLES are dropped; a final word still
// triggers emission. Writes to voxel_scale belong in idle time only.
module voxel_order_sort_partition
  import vosp_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = MaxParticlesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // pos_x[31:0], pos_y[63:32], pos_z[95:64]
  input  wire logic        s_tuser,  // final_particle
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // particle_index[5:0], partition[8:6], run_start[9], 0
  output logic             m_tlast,  // last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [31:0] scale;
  cmd_t cmd;
  sts_t sts;
  logic in_ok, in_fire;
  logic [5:0] o_index;
  logic [2:0] o_part;
  logic o_start;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) scale <= ScaleReset;
    else if (psel && penable && pwrite && paddr[1:0] == {RegScale, 1'b0} ) scale <= pwdata;
  end
  assign prdata = (paddr == {RegScale, 1'b0}) ? scale : 32'd0;

  assign s_tready = in_ok;
  assign in_fire = s_tvalid && s_tready;

  vosp_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_final(s_tuser),
    .out_free(!m_tvalid || m_tready), .sts, .in_ok, .cmd
  );

  vosp_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk, .rst, .cmd, .scale,
    .px(s_tdata[31:0]), .py(s_tdata[63:32]), .pz(s_tdata[95:64]),
    .out_take(m_tvalid && m_tready), .sts, .out_valid(m_tvalid),
    .o_index, .o_part, .o_start, .o_last(m_tlast)
  );

  assign m_tdata = {6'd0, o_start, o_part, o_index};

  // no input taken while more words of the set are still to come
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready) else $error("input accepted during emit");
  // a stalled output word holds still
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output word changed while stalled");
endmodule
`default_nettype wire

// File: tb/vosp_checker.sv
// vosp_checker: watches the particle load and sorted-index streams, predicts the
// sorted order from the positions and voxel_scale, and counts mismatches.
// Depends on vosp_pkg for the register address and the reset scale.
module vosp_checker
  import vosp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0] idx;
    logic [2:0] part;
    logic       run_start;
    logic       last;
  } sorted_word_t;

  logic [31:0]  scale_q;
  logic [63:0]  keys[64];
  logic [5:0]   owners[64];
  logic [2:0]   parities[64];
  logic [15:0]  vzs[64];
  int           set_size;
  sorted_word_t sorted_q[$];

  // Saturated floor(pos * scale / 2^32).
  function automatic logic [15:0] voxel_of(logic [31:0] p, logic [31:0] s);
    logic        neg;
    logic [63:0] mag, prod, q;
    neg  = p[31];
    mag  = neg ? {32'd0, 32'(-p)} : {32'd0, p};
    prod = mag * {32'd0, s};
    q    = prod >> 32;
    if (neg) begin
      if (prod[31:0] != 0) q = q + 1;
      if (q >= 32768) return 16'h8000;
      return 16'(-q[15:0]);
    end
    if (q > 32767) return 16'h7FFF;
    return q[15:0];
  endfunction

  task automatic place_particle(logic [95:0] d, logic fin);
    logic [15:0]  vx, vy, vz;
    logic [63:0]  key;
    int           slot;
    sorted_word_t w;
    if (set_size < 64) begin
      vx  = voxel_of(d[31:0], scale_q);
      vy  = voxel_of(d[63:32], scale_q);
      vz  = voxel_of(d[95:64], scale_q);
      key = {vx ^ 16'h8000, vy ^ 16'h8000, d[95:64] ^ 32'h8000_0000};
      slot = set_size;
      while (slot > 0 && keys[slot-1] > key) begin
        keys[slot] = keys[slot-1];
        owners[slot] = owners[slot-1];
        parities[slot] = parities[slot-1];
        vzs[slot] = vzs[slot-1];
        slot--;
      end
      keys[slot] = key;
      owners[slot] = 6'(set_size);
      parities[slot] = {vz[0], vy[0], vx[0]};
      vzs[slot] = vz;
      set_size++;
    end
    if (fin) begin
      for (int k = 0; k < set_size; k++) begin
        w.idx = owners[k];
        w.part = parities[k];
        w.run_start = (k == 0) || (keys[k][63:32] != keys[k-1][63:32]) || (vzs[k] != vzs[k-1]);
        w.last = (k + 1 == set_size);
        sorted_q = {sorted_q, w};
      end
      set_size = 0;
    end
  endtask

  always @(posedge clk) begin
    sorted_word_t exp_w, got;
    if (rst) begin
      scale_q <= ScaleReset;
      set_size = 0;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == {RegScale, 1'b0})
        scale_q <= pwdata;
      if (s_tvalid && s_tready) place_particle(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[5:0], m_tdata[8:6], m_tdata[9], m_tlast};
        if (sorted_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = sorted_q.pop_front();
          if (got !== exp_w || m_tdata[15:10] !== 0) begin
            if (fail_count < 10)
              $display("word mismatch: exp idx %0d part %0d rs %b last %b, got %h/%b",
                       exp_w.idx, exp_w.part, exp_w.run_start, exp_w.last, m_tdata, m_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = sorted_q.size();
  end
endmodule

// File: tb/tb_voxel_order_sort_partition.sv
// tb_voxel_order_sort_partition: drives particle sets and voxel_scale writes into
// the sort block with random gaps and stalls; vosp_checker predicts and compares.
// Depends on vosp_pkg, vosp_checker and the block RTL.
module tb_voxel_order_sort_partition
  import vosp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0, s_tuser = 0;
  logic [95:0] s_tdata = '0;
  logic        s_tready, m_tvalid, m_tlast, pready;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int          fail_count, pending;
  int          idle_cycles;   // watchdog: cycles with no word moving
  bit          stall_on = 1;

  always #1 clk = ~clk;

  voxel_order_sort_partition u_top (.*);

  vosp_checker u_chk (.*);

  // Watchdog; reports a mismatch and stops when no word moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output-side stalls: mostly short, a few long, some stretches free-running.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!stall_on || $urandom_range(0, 2) != 0) m_tready <= 1;
      else begin
        m_tready <= 0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_coord(int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 7)) << 16;   // small grid, shared voxels
      3: return -(32'($urandom_range(0, 7)) << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic apb_write(logic [31:0] v);
    paddr <= {RegScale, 1'b0}; pwdata <= v; pwrite <= 1; psel <= 1; penable <= 0;
    @(negedge clk); penable <= 1;
    @(negedge clk); psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Called at a falling edge; tready only moves at rising edges.
  task automatic send_word(logic [95:0] d, logic fin);
    int gap;
    s_tvalid <= 1; s_tdata <= d; s_tuser <= fin;
    while (!s_tready) @(negedge clk);
    @(negedge clk);
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 0;
      if ($urandom_range(0, 12) == 0) gap = $urandom_range(10, 30);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_set(int n, int mode);
    logic [95:0] d;
    for (int i = 0; i < n; i++) begin
      d = {pick_coord(mode < 0 ? $urandom_range(0, 4) : mode),
           pick_coord($urandom_range(2, 4)), pick_coord($urandom_range(0, 4))};
      if ($urandom_range(0, 3) == 0) d = {$urandom, $urandom, $urandom};
      send_word(d, i == n - 1);
    end
  endtask

  // Drain: all expected words out, then latency slack before touching the register.
  task automatic drain;
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    logic [31:0] scales[5];
    scales = '{32'd1, 32'hFFFF_FFFF, 32'd16384, 32'd65536, 32'd0};
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Directed: single-particle set, extremes, ties, and an overfull set.
    send_word({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1);
    send_word({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0);
    send_word({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0);
    send_word({32'h0, 32'hFFFF_FFFF, 32'h0001_0000}, 0);
    send_word({32'hFFFF_FFFF, 32'h0, 32'hFFFE_0000}, 1);
    drain();
    apb_write(32'hFFFF_FFFF);
    send_set(5, 0);
    send_set(4, 1);
    drain();
    apb_write(32'd0);   // scale zero: all voxels 0, order by raw z
    send_set(4, -1);
    drain();
    apb_write(32'd1 << 20);
    stall_on = 0;
    send_set(66, 2);    // capacity overflow, final still emits
    stall_on = 1;
    // Random sets over several scales.
    for (int p = 0; p < 5; p++) begin
      drain();
      apb_write(scales[p] == 0 ? $urandom : scales[p]);
      repeat (3) send_set($urandom_range(1, 15), -1);
    end
    drain();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/vosp_pkg.sv
hw/rtl/vosp_ctrl.sv
hw/rtl/vosp_dp.sv
hw/rtl/voxel_order_sort_partition.sv
tb/vosp_checker.sv
tb/tb_voxel_order_sort_partition.sv
